FILE: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Command and status codes shared by the double-ended queue and its channels.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef enum logic [1:0] {
    CMD_TAKE_FRONT = 2'd0,
    CMD_TAKE_BACK  = 2'd1,
    CMD_PUT_FRONT  = 2'd2,
    CMD_PUT_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

endpackage

FILE: hw/rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic              valid;
  logic              ready;
  deq_pkg::cmd_t     cmd;
  deq_pkg::word_t    value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface deq_out_if #(
  parameter int FILL_W = 5
);
  logic              valid;
  logic              ready;
  deq_pkg::word_t    data_out;
  deq_pkg::status_t  status;
  logic [FILL_W-1:0] fill_level;

  modport source (output valid, output data_out, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input data_out, input status, input fill_level,
                  output ready);
endinterface

FILE: hw/rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed words held in a circular buffer memory.
// ----------------------------------------------------------------------------
// A command's result passes through the synchronous memory read in the issue
// stage and then through the output register.
// Throughput: one command per cycle while the output channel is not stalled.
// Reset (synchronous, active low) empties the queue; memory contents are not
// cleared, since only written entries are ever read.
module double_ended_queue_top #(
  parameter int DEPTH  = 16,
  parameter int FILL_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  deq_in_if.sink            in_chan,
  deq_out_if.source         out_chan
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  deq_pkg::word_t    mem [DEPTH];
  deq_pkg::word_t    rdata_r;

  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [FILL_W-1:0] count_r, count_nxt;

  // Issue stage: one command waiting for its read data.
  logic              s1_valid_r;
  logic              s1_take_r;
  deq_pkg::status_t  s1_status_r, status_nxt;
  logic [FILL_W-1:0] s1_fill_r;

  logic              out_valid_r;
  deq_pkg::word_t    out_data_r;
  deq_pkg::status_t  out_status_r;
  logic [FILL_W-1:0] out_fill_r;

  logic              s1_move;
  logic              in_xfer;
  logic              full;
  logic              empty;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     head_inc, head_dec, tail_inc, tail_dec;

  assign s1_move      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_move;
  assign in_xfer      = in_chan.valid && in_chan.ready;

  assign full  = (count_r == FILL_W'(DEPTH));
  assign empty = (count_r == '0);

  // Pointer steps with wrap-around for any depth.
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - 1'b1;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = deq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = tail_r;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    if (in_xfer) begin
      case (in_chan.cmd)
        deq_pkg::CMD_PUT_BACK: begin
          if (full) begin
            status_nxt = deq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = tail_r;
            tail_nxt  = tail_inc;
            count_nxt = count_r + 1'b1;
          end
        end
        deq_pkg::CMD_PUT_FRONT: begin
          if (full) begin
            status_nxt = deq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = head_dec;
            head_nxt  = head_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        deq_pkg::CMD_TAKE_BACK: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = tail_dec;
            tail_nxt  = tail_dec;
            count_nxt = count_r - 1'b1;
          end
        end
        deq_pkg::CMD_TAKE_FRONT: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = deq_pkg::ST_OK;
        end
      endcase
    end
  end

  // A write lands at the clock edge, so a take in the following cycle
  // already reads the new word; no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_chan.value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers; the read data holds while the issue stage is stalled
  // because no new read is started then.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_take_r   <= rd_en;
      s1_status_r <= status_nxt;
      s1_fill_r   <= count_nxt;
    end
    if (s1_move) begin
      out_data_r   <= s1_take_r ? rdata_r : '0;
      out_status_r <= s1_status_r;
      out_fill_r   <= s1_fill_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.data_out   = out_data_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.fill_level = out_fill_r;

endmodule
